@@ rtl/hctt_pkg.sv @@
// shared types, codes and constants of the hot/cold tier tracker
`default_nettype none
package hctt_pkg;

	// widths fixed by the field definitions
	localparam int unsigned KEY_W = 64;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned TOT_W = 64;
	localparam int unsigned TIER_W = 2;
	localparam int unsigned REQ_W = 3;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned PERIOD_W = 11;
	localparam int unsigned PHASE_W = 10;
	localparam int unsigned ENTRY_W = KEY_W + 2 * CNT_W;

	// table size default
	localparam int unsigned TABLE_ENTRIES_DEF = 64;

	// register reset values and period limit
	localparam logic [CNT_W-1:0] PROMOTE_THR_RST = 32'd8;
	localparam logic [CNT_W-1:0] DEMOTE_THR_RST = 32'd30;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 11'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'd1024;

	// tier codes
	localparam logic [TIER_W-1:0] TIER_TOP = 2'd0;
	localparam logic [TIER_W-1:0] TIER_BOTTOM = 2'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ACCESS = 3'd0,
		REQ_TICK = 3'd1,
		REQ_EVAL = 3'd2,
		REQ_PROMOTE = 3'd3,
		REQ_DEMOTE = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE = 2'd0,
		ST_LIMIT = 2'd1,
		ST_UNTRACKED = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROMOTE_THR = 2'd0,
		CFG_DEMOTE_THR = 2'd1,
		CFG_EVAL_PERIOD = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_HIT,
		S_MISS,
		S_OTHER
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic fin_hit;
		logic fin_miss;
		logic fin_other;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_search;
		logic table_empty;
		logic match;
		logic last;
	} dp_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

@@ rtl/hot_cold_tier_tracker.sv @@
// top level of the hot/cold tier tracker
//
// Commands enter on start while busy is low, with req_type, obj_key,
// current_tier and is_system_metadata. One result follows each command:
// done is high for exactly one cycle with new_tier, tier_changed, status,
// eval_now and the two running totals; the receiver cannot stall it.
// Access, evaluate and manual promote (below the top tier) scan the table
// one entry at a time through its ram read port (read, compare).
// Entries are allocated in order and never freed, so the scan covers only
// the filled entries. The scan ends on a hit or after the last filled
// entry; tick, manual demote and other commands skip it.
// A new command is taken in the cycle that done is shown.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and must be made by the user while no command is in flight; the block
// itself does not enforce this. Reset clears the fill count, tick phase,
// totals and sets the thresholds and period to their defaults; no clearing
// pass is needed.
`default_nettype none
module hot_cold_tier_tracker import hctt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [REQ_W-1:0] req_type,
	input wire logic [KEY_W-1:0] obj_key,
	input wire logic [TIER_W-1:0] current_tier,
	input wire logic is_system_metadata,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic done,
	output logic [TIER_W-1:0] new_tier,
	output logic tier_changed,
	output logic [STAT_W-1:0] status,
	output logic eval_now,
	output logic [TOT_W-1:0] total_accesses,
	output logic [TOT_W-1:0] total_promotions
);

	dp_cmd_t cmd;
	dp_stat_t stat;

	// sequencer
	hctt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.busy(busy),
		.cmd(cmd)
	);

	// datapath
	hctt_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.req_type(req_type),
		.obj_key(obj_key),
		.current_tier(current_tier),
		.is_system_metadata(is_system_metadata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.new_tier(new_tier),
		.tier_changed(tier_changed),
		.status(status),
		.eval_now(eval_now),
		.total_accesses(total_accesses),
		.total_promotions(total_promotions)
	);

endmodule
`default_nettype wire

@@ rtl/hctt_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module hctt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/hctt_ctrl.sv @@
// sequencer for the table scan and result issue
`default_nettype none
module hctt_ctrl import hctt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire dp_stat_t stat,
	output logic busy,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					cmd.idx_clr = 1'b1;
					if (stat.need_search && !stat.table_empty) begin
						state_d = S_READ;
					end else if (stat.need_search) begin
						state_d = S_MISS;
					end else begin
						state_d = S_OTHER;
					end
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (stat.match) begin
					state_d = S_HIT;
				end else if (stat.last) begin
					state_d = S_MISS;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_READ;
				end
			end
			S_HIT: begin
				cmd.fin_hit = 1'b1;
				state_d = S_IDLE;
			end
			S_MISS: begin
				cmd.fin_miss = 1'b1;
				state_d = S_IDLE;
			end
			S_OTHER: begin
				cmd.fin_other = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/hctt_dp.sv @@
// datapath: request registers, entry table, counters and result registers
`default_nettype none
module hctt_dp import hctt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dp_cmd_t cmd,
	output dp_stat_t stat,
	input wire logic [REQ_W-1:0] req_type,
	input wire logic [KEY_W-1:0] obj_key,
	input wire logic [TIER_W-1:0] current_tier,
	input wire logic is_system_metadata,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic done,
	output logic [TIER_W-1:0] new_tier,
	output logic tier_changed,
	output logic [STAT_W-1:0] status,
	output logic eval_now,
	output logic [TOT_W-1:0] total_accesses,
	output logic [TOT_W-1:0] total_promotions
);

	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned FW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_ENTRIES);

	logic [CNT_W-1:0] promote_thr_q, demote_thr_q;
	logic [PERIOD_W-1:0] period_q;
	logic [REQ_W-1:0] req_q;
	logic [KEY_W-1:0] key_q;
	logic [TIER_W-1:0] tier_q;
	logic meta_q;
	logic [IW-1:0] idx_q;
	logic [FW-1:0] fill_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TOT_W-1:0] acc_tot_q, prom_tot_q;

	logic [TIER_W-1:0] tier_in;
	logic [ENTRY_W-1:0] rd_entry, wr_entry;
	logic [KEY_W-1:0] rd_key;
	logic [CNT_W-1:0] rd_hits, rd_idle;
	logic ram_we;
	logic [IW-1:0] ram_waddr;
	logic table_full, finish;

	logic [TIER_W-1:0] nt;
	logic ch, ev, prom;
	status_t st;
	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W-1:0] phase_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			promote_thr_q <= PROMOTE_THR_RST;
			demote_thr_q <= DEMOTE_THR_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROMOTE_THR: promote_thr_q <= cfg_data;
				CFG_DEMOTE_THR: demote_thr_q <= cfg_data;
				CFG_EVAL_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// tier code three reads as bottom
	assign tier_in = (current_tier > TIER_BOTTOM) ? TIER_BOTTOM : current_tier;

	// status to controller
	assign stat.need_search = (req_type == REQ_ACCESS) || (req_type == REQ_EVAL) ||
		((req_type == REQ_PROMOTE) && (tier_in != TIER_TOP));
	assign stat.table_empty = (fill_q == '0);
	assign stat.match = (rd_key == key_q);
	assign stat.last = (FW'(idx_q) + 1'b1 == fill_q);

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= obj_key;
			tier_q <= tier_in;
			meta_q <= is_system_metadata;
		end
	end

	// scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// entry table: key, hit count, idle count
	hctt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES),
		.AW(IW)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.re(cmd.rd_en),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	assign rd_key = rd_entry[ENTRY_W-1 -: KEY_W];
	assign rd_hits = rd_entry[2*CNT_W-1 -: CNT_W];
	assign rd_idle = rd_entry[CNT_W-1:0];
	assign table_full = (fill_q == FILL_MAX);
	assign finish = cmd.fin_hit || cmd.fin_miss || cmd.fin_other;

	// tick period clamp and phase step
	always_comb begin
		if (period_q == '0) begin
			period_eff = PERIOD_W'(1);
		end else if (period_q > PERIOD_MAX) begin
			period_eff = PERIOD_MAX;
		end else begin
			period_eff = period_q;
		end
		phase_next = PERIOD_W'(phase_q) + 1'b1;
	end

	// result and entry update for the finishing request
	always_comb begin
		nt = tier_q;
		ch = 1'b0;
		st = ST_DONE;
		ev = 1'b0;
		prom = 1'b0;
		ram_we = 1'b0;
		ram_waddr = idx_q;
		wr_entry = {key_q, {CNT_W{1'b0}}, {CNT_W{1'b0}}};
		priority if (req_q == REQ_ACCESS) begin
			if (cmd.fin_hit) begin
				ram_we = 1'b1;
				wr_entry = {key_q, sat_inc(rd_hits), {CNT_W{1'b0}}};
			end else if (cmd.fin_miss && table_full) begin
				st = ST_FULL;
			end else if (cmd.fin_miss) begin
				ram_we = 1'b1;
				ram_waddr = fill_q[IW-1:0];
				wr_entry = {key_q, CNT_W'(1), {CNT_W{1'b0}}};
			end
		end else if (req_q == REQ_TICK) begin
			ev = (phase_next >= period_eff);
		end else if (req_q == REQ_EVAL) begin
			if (cmd.fin_miss) begin
				st = ST_UNTRACKED;
			end else if (cmd.fin_hit) begin
				ram_we = 1'b1;
				if (rd_hits > promote_thr_q && tier_q != TIER_TOP) begin
					nt = tier_q - 1'b1;
					ch = 1'b1;
					prom = 1'b1;
				end else if (rd_hits == '0 && rd_idle > demote_thr_q &&
						tier_q != TIER_BOTTOM && !meta_q) begin
					nt = tier_q + 1'b1;
					ch = 1'b1;
				end
				wr_entry = {key_q, {CNT_W{1'b0}},
					(rd_hits == '0) ? sat_inc(rd_idle) : {CNT_W{1'b0}}};
			end
		end else if (req_q == REQ_PROMOTE) begin
			if (tier_q == TIER_TOP) begin
				st = ST_LIMIT;
			end else begin
				nt = tier_q - 1'b1;
				ch = 1'b1;
				ram_we = cmd.fin_hit;
			end
		end else if (req_q == REQ_DEMOTE) begin
			if (tier_q == TIER_BOTTOM) begin
				st = ST_LIMIT;
			end else begin
				nt = tier_q + 1'b1;
				ch = 1'b1;
			end
		end else begin
			nt = tier_q;
		end
	end

	// fill count, tick phase and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			phase_q <= '0;
			acc_tot_q <= '0;
			prom_tot_q <= '0;
		end else if (finish) begin
			if (cmd.fin_miss && req_q == REQ_ACCESS && !table_full) begin
				fill_q <= fill_q + 1'b1;
			end
			if (req_q == REQ_ACCESS) begin
				acc_tot_q <= acc_tot_q + 1'b1;
			end
			if (prom) begin
				prom_tot_q <= prom_tot_q + 1'b1;
			end
			if (req_q == REQ_TICK) begin
				phase_q <= ev ? '0 : phase_next[PHASE_W-1:0];
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= finish;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (finish) begin
			new_tier <= nt;
			tier_changed <= ch;
			status <= st;
			eval_now <= ev;
			total_accesses <= (req_q == REQ_ACCESS) ? acc_tot_q + 1'b1 : acc_tot_q;
			total_promotions <= prom ? prom_tot_q + 1'b1 : prom_tot_q;
		end
	end

endmodule
`default_nettype wire

@@ tb/hctt_checker.sv @@
// checker for the hot/cold tier tracker: predicts each result and compares it
`default_nettype none
module hctt_checker import hctt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [REQ_W-1:0] req_type,
	input wire logic [KEY_W-1:0] obj_key,
	input wire logic [TIER_W-1:0] current_tier,
	input wire logic is_system_metadata,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic done,
	input wire logic [TIER_W-1:0] new_tier,
	input wire logic tier_changed,
	input wire logic [STAT_W-1:0] status,
	input wire logic eval_now,
	input wire logic [TOT_W-1:0] total_accesses,
	input wire logic [TOT_W-1:0] total_promotions,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [TIER_W-1:0] tier;
		logic changed;
		logic [STAT_W-1:0] stat;
		logic evnow;
		logic [TOT_W-1:0] accesses;
		logic [TOT_W-1:0] promotions;
	} tier_result_t;

	// shadow of the tracker state
	logic [CNT_W-1:0] promote_thr, demote_thr;
	logic [PERIOD_W-1:0] period_reg;
	logic slot_valid [TABLE_ENTRIES];
	logic [KEY_W-1:0] slot_key [TABLE_ENTRIES];
	logic [CNT_W-1:0] slot_hits [TABLE_ENTRIES];
	logic [CNT_W-1:0] slot_idle [TABLE_ENTRIES];
	logic [PHASE_W-1:0] phase;
	logic [TOT_W-1:0] access_cnt, promo_cnt;
	tier_result_t expected_q [$];

	assign pending = expected_q.size();

	function automatic int lookup(input logic [KEY_W-1:0] key);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (slot_valid[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// compute the result of one transaction and update the shadow state
	function automatic tier_result_t predict_tier(input logic [REQ_W-1:0] req,
			input logic [KEY_W-1:0] key, input logic [TIER_W-1:0] tier_in,
			input logic meta);
		tier_result_t r;
		logic [TIER_W-1:0] tier;
		int idx;
		int free;
		int unsigned per;
		int unsigned nxt;
		logic [CNT_W-1:0] hits;
		r = '0;
		tier = (tier_in > TIER_BOTTOM) ? TIER_BOTTOM : tier_in;
		r.stat = ST_DONE;
		case (req)
			REQ_ACCESS: begin
				access_cnt++;
				idx = lookup(key);
				if (idx >= 0) begin
					slot_hits[idx] = bump(slot_hits[idx]);
					slot_idle[idx] = '0;
				end else begin
					free = -1;
					for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
						if (!slot_valid[i])
							free = i;
					if (free >= 0) begin
						slot_valid[free] = 1'b1;
						slot_key[free] = key;
						slot_hits[free] = CNT_W'(1);
						slot_idle[free] = '0;
					end else
						r.stat = ST_FULL;
				end
			end
			REQ_TICK: begin
				per = 32'(period_reg);
				if (per == 0)
					per = 1;
				if (per > PERIOD_MAX)
					per = 32'(PERIOD_MAX);
				nxt = phase + 1;
				if (nxt >= per) begin
					r.evnow = 1'b1;
					phase = '0;
				end else
					phase = nxt[PHASE_W-1:0];
			end
			REQ_EVAL: begin
				idx = lookup(key);
				if (idx < 0)
					r.stat = ST_UNTRACKED;
				else begin
					hits = slot_hits[idx];
					if (hits > promote_thr && tier > TIER_TOP) begin
						tier--;
						r.changed = 1'b1;
						promo_cnt++;
					end else if (hits == 0 && slot_idle[idx] > demote_thr &&
							tier < TIER_BOTTOM && !meta) begin
						tier++;
						r.changed = 1'b1;
					end
					slot_idle[idx] = (hits == 0) ? bump(slot_idle[idx]) : '0;
					slot_hits[idx] = '0;
				end
			end
			REQ_PROMOTE: begin
				if (tier == TIER_TOP)
					r.stat = ST_LIMIT;
				else begin
					tier--;
					r.changed = 1'b1;
					idx = lookup(key);
					if (idx >= 0) begin
						slot_idle[idx] = '0;
						slot_hits[idx] = '0;
					end
				end
			end
			REQ_DEMOTE: begin
				if (tier == TIER_BOTTOM)
					r.stat = ST_LIMIT;
				else begin
					tier++;
					r.changed = 1'b1;
				end
			end
			default: ;
		endcase
		r.tier = tier;
		r.accesses = access_cnt;
		r.promotions = promo_cnt;
		return r;
	endfunction

	task automatic report(input string what, input logic [TOT_W-1:0] got,
			input logic [TOT_W-1:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// watch the config port, commands and results
	always @(posedge clk or negedge arst_n) begin
		tier_result_t e;
		if (!arst_n) begin
			promote_thr = PROMOTE_THR_RST;
			demote_thr = DEMOTE_THR_RST;
			period_reg = PERIOD_RST;
			phase = '0;
			access_cnt = '0;
			promo_cnt = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				slot_valid[i] = 1'b0;
				slot_hits[i] = '0;
				slot_idle[i] = '0;
			end
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_we)
				case (cfg_index)
					CFG_PROMOTE_THR: promote_thr = cfg_data;
					CFG_DEMOTE_THR: demote_thr = cfg_data;
					CFG_EVAL_PERIOD: period_reg = cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result transaction", $realtime);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (new_tier !== e.tier)
						report("new_tier", TOT_W'(new_tier), TOT_W'(e.tier));
					if (tier_changed !== e.changed)
						report("tier_changed", TOT_W'(tier_changed), TOT_W'(e.changed));
					if (status !== e.stat)
						report("status", TOT_W'(status), TOT_W'(e.stat));
					if (eval_now !== e.evnow)
						report("eval_now", TOT_W'(eval_now), TOT_W'(e.evnow));
					if (total_accesses !== e.accesses)
						report("total_accesses", total_accesses, e.accesses);
					if (total_promotions !== e.promotions)
						report("total_promotions", total_promotions, e.promotions);
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_tier(req_type, obj_key, current_tier,
					is_system_metadata));
		end
	end
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// top of the tier tracker testbench: clock, reset, stimulus and verdict
`default_nettype none
module testbench import hctt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0, arst_n = 1'b0;
	logic start = 1'b0;
	logic [REQ_W-1:0] req_type = '0;
	logic [KEY_W-1:0] obj_key = '0;
	logic [TIER_W-1:0] current_tier = '0;
	logic is_system_metadata = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire logic busy, done, tier_changed, eval_now;
	wire logic [TIER_W-1:0] new_tier;
	wire logic [STAT_W-1:0] status;
	wire logic [TOT_W-1:0] total_accesses, total_promotions;
	int errors, pending, cycles;
	int idle_pct;
	logic [KEY_W-1:0] hot_keys [16];

	localparam int CYCLE_LIMIT = 2000000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hot_cold_tier_tracker u_top (.*);
	hctt_checker u_chk (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// start stays high after acceptance until the next send or drain changes it
	task automatic send(input logic [REQ_W-1:0] rq, input logic [KEY_W-1:0] key,
			input logic [TIER_W-1:0] tr, input logic meta);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		obj_key <= key;
		current_tier <= tr;
		is_system_metadata <= meta;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly hot-set accesses, evaluations and ticks on a small key set
	task automatic random_phase(input int n);
		logic [KEY_W-1:0] k;
		int sel;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
				: hot_keys[$urandom_range(15)];
			sel = $urandom_range(99);
			if (sel < 45) send(REQ_ACCESS, k, TIER_W'($urandom), 1'($urandom));
			else if (sel < 65) send(REQ_EVAL, k, TIER_W'($urandom), 1'($urandom));
			else if (sel < 80) send(REQ_TICK, k, TIER_W'($urandom), 1'($urandom));
			else if (sel < 88) send(REQ_PROMOTE, k, TIER_W'($urandom), 1'($urandom));
			else if (sel < 96) send(REQ_DEMOTE, k, TIER_W'($urandom), 1'($urandom));
			else send(REQ_W'($urandom_range(7)), k, TIER_W'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		idle_pct = 0;
		for (int i = 0; i < 16; i++)
			hot_keys[i] = {$urandom, $urandom};
		hot_keys[0] = '0;
		hot_keys[1] = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every request type, tier extremes, code three, unknown types
		send(REQ_EVAL, '0, 2'd1, 1'b0);
		for (int i = 0; i < 10; i++) send(REQ_ACCESS, '1, 2'd3, 1'b1);
		send(REQ_EVAL, '1, 2'd3, 1'b0);
		send(REQ_EVAL, '1, 2'd0, 1'b0);
		send(REQ_PROMOTE, '1, 2'd0, 1'b0);
		send(REQ_PROMOTE, '1, 2'd3, 1'b0);
		send(REQ_DEMOTE, '0, 2'd2, 1'b1);
		send(REQ_DEMOTE, '0, 2'd0, 1'b0);
		send(3'd5, '0, 2'd1, 1'b0);
		send(3'd7, '1, 2'd1, 1'b1);
		for (int i = 0; i < 11; i++) send(REQ_TICK, KEY_W'(i), 2'd3, 1'b0);
		drain();

		// quick demote: idle threshold zero, metadata vs not
		write_reg(CFG_DEMOTE_THR, 32'd0);
		write_reg(CFG_PROMOTE_THR, 32'd0);
		write_reg(CFG_EVAL_PERIOD, 32'd0);
		send(REQ_ACCESS, 64'h5, 2'd1, 1'b0);
		for (int i = 0; i < 4; i++) send(REQ_EVAL, 64'h5, 2'd0, i[0]);
		send(REQ_TICK, '0, 2'd0, 1'b0);
		send(REQ_TICK, '0, 2'd0, 1'b0);
		drain();

		// fill the table past its capacity
		for (int i = 0; i < 66; i++) send(REQ_ACCESS, 64'h1000 + KEY_W'(i), 2'd1, 1'b0);
		drain();
		write_reg(CFG_EVAL_PERIOD, 32'd1024);
		write_reg(CFG_PROMOTE_THR, 32'hFFFFFFFF);
		write_reg(CFG_DEMOTE_THR, 32'hFFFFFFFF);
		for (int i = 0; i < 20; i++) send(REQ_TICK, '0, 2'd0, 1'b0);
		drain();
		// period beyond the limit, then shorter than the phase
		write_reg(CFG_EVAL_PERIOD, 32'h7FF);
		send(REQ_TICK, '0, 2'd0, 1'b0);
		drain();
		write_reg(CFG_EVAL_PERIOD, 32'd3);
		send(REQ_TICK, '0, 2'd0, 1'b0);
		drain();

		// random phases; table is full so hot keys are from the fill range
		for (int i = 0; i < 16; i++)
			hot_keys[i] = 64'h1000 + KEY_W'($urandom_range(65));
		write_reg(CFG_PROMOTE_THR, 32'd2);
		write_reg(CFG_DEMOTE_THR, 32'd1);
		write_reg(CFG_EVAL_PERIOD, 32'd4);
		idle_pct = 14;
		random_phase(360);
		drain();
		write_reg(CFG_PROMOTE_THR, 32'd0);
		write_reg(CFG_DEMOTE_THR, 32'd3);
		write_reg(CFG_EVAL_PERIOD, 32'd1);
		idle_pct = 66;
		random_phase(360);
		drain();
		write_reg(CFG_PROMOTE_THR, 32'd1);
		write_reg(CFG_DEMOTE_THR, 32'd0);
		write_reg(CFG_EVAL_PERIOD, 32'd7);
		idle_pct = 0;
		random_phase(360);
		drain();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
